### rtl/core/ntssd_pkg.sv
// Package for number_to_seven_segment_digits: widths, defaults, BCD cell
// mode codes, a control struct and the segment decode function. No dependencies.
package ntssd_pkg;

    localparam int VALUE_W          = 48;
    localparam int DCOUNT_W         = 4;
    localparam int IDX_W            = 3;
    localparam int SEG_W            = 8;
    localparam int MAX_DISPLAYS_DEF = 8;
    localparam int FRAC_BITS_DEF    = 16;

    localparam logic [DCOUNT_W-1:0] DCOUNT_RESET = 4'd4;

    localparam logic [SEG_W-1:0] SEG_DP    = 8'd128;
    localparam logic [SEG_W-1:0] SEG_E     = 8'd121;
    localparam logic [SEG_W-1:0] SEG_R     = 8'd80;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'd0;

    typedef logic [2:0] cell_mode_t;

    localparam cell_mode_t CELL_HOLD   = 3'd0;
    localparam cell_mode_t CELL_CLEAR  = 3'd1;
    localparam cell_mode_t CELL_DABBLE = 3'd2;
    localparam cell_mode_t CELL_SHL    = 3'd3;
    localparam cell_mode_t CELL_SHR    = 3'd4;
    localparam cell_mode_t CELL_INC    = 3'd5;

    typedef struct packed {
        logic load;
        logic step;
    } frac_ctl_t;

    function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'd63;
            4'd1:    s = 8'd6;
            4'd2:    s = 8'd91;
            4'd3:    s = 8'd79;
            4'd4:    s = 8'd102;
            4'd5:    s = 8'd109;
            4'd6:    s = 8'd125;
            4'd7:    s = 8'd7;
            4'd8:    s = 8'd127;
            4'd9:    s = 8'd111;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/ntssd_cell.sv
// One BCD digit cell of the conversion chain: hold, clear, add-3 shift, decimal shifts
// both ways and increment with ripple carry. Depends on ntssd_pkg.
module ntssd_cell
    import ntssd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_mode_t mode,
    input  logic       bit_in,
    input  logic [3:0] digit_lo_in,
    input  logic [3:0] digit_hi_in,
    input  logic       carry_in,
    output logic [3:0] digit,
    output logic       bit_out,
    output logic       carry_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;
    logic [4:0] sum;

    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out   = adj[3];
    assign sum       = {1'b0, digit_reg} + {4'b0, carry_in};
    assign carry_out = (sum == 5'd10);
    assign digit     = digit_reg;

    always_comb
    begin
        case (mode)
            CELL_HOLD:   digit_next = digit_reg;
            CELL_CLEAR:  digit_next = 4'd0;
            CELL_DABBLE: digit_next = {adj[2:0], bit_in};
            CELL_SHL:    digit_next = digit_lo_in;
            CELL_SHR:    digit_next = digit_hi_in;
            CELL_INC:    digit_next = carry_out ? 4'd0 : sum[3:0];
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

### rtl/core/ntssd_frac.sv
// Fraction digit generator: multiplies the held fraction by ten each step,
// handing the integer digit to the cell chain. Depends on ntssd_pkg.
module ntssd_frac
    import ntssd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  frac_ctl_t            ctl,
    input  logic [FRAC_BITS-1:0] load_value,
    output logic [3:0]           digit,
    output logic                 round_bit
);

    logic [FRAC_BITS-1:0] frac_reg;
    logic [FRAC_BITS-1:0] frac_next;
    logic [FRAC_BITS+3:0] times10;

    assign times10   = ({4'b0, frac_reg} << 3) + ({4'b0, frac_reg} << 1);
    assign digit     = times10[FRAC_BITS+3:FRAC_BITS];
    assign round_bit = frac_reg[FRAC_BITS-1];

    always_comb
    begin
        if (ctl.load)
            frac_next = load_value;
        else if (ctl.step)
            frac_next = times10[FRAC_BITS-1:0];
        else
            frac_next = frac_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= '0;
        end
        else
        begin
            frac_reg <= frac_next;
        end
    end

endmodule

### rtl/core/number_to_seven_segment_digits.sv
// Top level: fixed-point value to seven-segment patterns, one output word per display.
// Flow: integer bits are double-dabbled through the BCD chain and checked, then s fraction
// digits (s spare displays) are shifted in, rounded and checked; all-zero ones shift out.
// n words follow, one per cycle while m_tready is high; next value only after the last.
// Reset: display_count returns to 4, controller idle, no words pending.
// Depends on ntssd_pkg, ntssd_cell, ntssd_frac.
module number_to_seven_segment_digits
    import ntssd_pkg::*;
#(
    parameter int MAX_DISPLAYS = MAX_DISPLAYS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DCOUNT_W-1:0] cfg_data,    // display_count
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,     // value[47:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,     // display_index[2:0], segments[10:3], zero
    output logic                m_tlast      // last
);

    localparam int IW   = VALUE_W - FRAC_BITS;
    localparam int CMAX = (IW > MAX_DISPLAYS) ? IW : MAX_DISPLAYS;
    localparam int CNTW = $clog2(CMAX + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DAB  = 4'd1;
    localparam logic [3:0] ST_CHK  = 4'd2;
    localparam logic [3:0] ST_FRAC = 4'd3;
    localparam logic [3:0] ST_RND  = 4'd4;
    localparam logic [3:0] ST_CHK2 = 4'd5;
    localparam logic [3:0] ST_ADJ  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [DCOUNT_W-1:0] dcount_reg, dcount_next;
    logic [IW-1:0]       ip_reg, ip_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic                err_reg, err_next;
    logic                dp_reg, dp_next;
    logic [DCOUNT_W-1:0] s_reg, s_next;
    logic [DCOUNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic [3:0]          dig  [MAX_DISPLAYS];
    logic                bout [MAX_DISPLAYS];
    logic                cout [MAX_DISPLAYS];
    cell_mode_t          mode;
    frac_ctl_t           fctl;
    logic [3:0]          frac_digit;
    logic                round_bit;

    logic [DCOUNT_W-1:0] n_eff;
    logic [DCOUNT_W-1:0] nz_top;
    logic                low_nz;
    logic                hi_err;
    logic [DCOUNT_W-1:0] d_cnt;
    logic [DCOUNT_W-1:0] idx4;
    logic                in_acc, out_acc, is_last;
    logic [SEG_W-1:0]    seg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;

    always_comb
    begin
        if (dcount_reg == '0)
            n_eff = DCOUNT_W'(1);
        else if (dcount_reg > DCOUNT_W'(MAX_DISPLAYS))
            n_eff = DCOUNT_W'(MAX_DISPLAYS);
        else
            n_eff = dcount_reg;
    end

    always_comb
    begin
        nz_top = '0;
        low_nz = 1'b0;
        for (int i = 0; i < MAX_DISPLAYS; i++)
        begin
            if (dig[i] != 4'd0)
                nz_top = DCOUNT_W'(i + 1);
            if ((DCOUNT_W'(i) < s_reg) && (dig[i] != 4'd0))
                low_nz = 1'b1;
        end
    end

    assign hi_err = ovf_reg || (nz_top > n_eff);
    assign d_cnt  = (nz_top == '0) ? DCOUNT_W'(1) : nz_top;

    // BCD digit chain, cell 0 least significant
    genvar g;
    generate
        for (g = 0; g < MAX_DISPLAYS; g++)
        begin : g_cell
            logic       b_in;
            logic [3:0] lo_in;
            logic [3:0] hi_in;
            logic       c_in;
            if (g == 0)
            begin : g_first
                assign b_in  = ip_reg[IW-1];
                assign lo_in = frac_digit;
                assign c_in  = round_bit;
            end
            else
            begin : g_rest
                assign b_in  = bout[g-1];
                assign lo_in = dig[g-1];
                assign c_in  = cout[g-1];
            end
            if (g == MAX_DISPLAYS - 1)
            begin : g_top
                assign hi_in = 4'd0;
            end
            else
            begin : g_mid
                assign hi_in = dig[g+1];
            end
            ntssd_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .mode        (mode),
                .bit_in      (b_in),
                .digit_lo_in (lo_in),
                .digit_hi_in (hi_in),
                .carry_in    (c_in),
                .digit       (dig[g]),
                .bit_out     (bout[g]),
                .carry_out   (cout[g])
            );
        end
    endgenerate

    ntssd_frac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (fctl),
        .load_value (s_tdata[FRAC_BITS-1:0]),
        .digit      (frac_digit),
        .round_bit  (round_bit)
    );

    // output word
    assign idx4    = DCOUNT_W'(idx_reg);
    assign is_last = (idx4 + DCOUNT_W'(1) == n_eff);

    always_comb
    begin
        if (err_reg)
        begin
            if (is_last)
                seg = SEG_E;
            else if ((idx4 + DCOUNT_W'(2) == n_eff) || (idx4 + DCOUNT_W'(3) == n_eff))
                seg = SEG_R;
            else
                seg = SEG_BLANK;
        end
        else if (idx4 < used_reg)
        begin
            seg = digit_seg(dig[0]);
            if (dp_reg && (idx4 == s_reg))
                seg = seg | SEG_DP;
        end
        else
        begin
            seg = SEG_BLANK;
        end
    end

    assign m_tdata = {5'b0, seg, idx_reg};
    assign m_tlast = is_last;

    always_comb
    begin
        state_next  = state_reg;
        dcount_next = dcount_reg;
        ip_next     = ip_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        err_next    = err_reg;
        dp_next     = dp_reg;
        s_next      = s_reg;
        used_next   = used_reg;
        idx_next    = idx_reg;
        mode        = CELL_HOLD;
        fctl        = '0;

        if (cfg_valid && cfg_ready)
            dcount_next = cfg_data;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    ip_next    = s_tdata[VALUE_W-1:FRAC_BITS];
                    fctl.load  = 1'b1;
                    mode       = CELL_CLEAR;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    err_next   = 1'b0;
                    dp_next    = 1'b0;
                    s_next     = '0;
                    state_next = ST_DAB;
                end
            end
            ST_DAB:
            begin
                mode     = CELL_DABBLE;
                ip_next  = ip_reg << 1;
                ovf_next = ovf_reg | bout[MAX_DISPLAYS-1];
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(IW - 1))
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cnt_next = '0;
                if (hi_err)
                begin
                    err_next   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else if (n_eff == d_cnt)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    s_next     = n_eff - d_cnt;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                mode      = CELL_SHL;
                fctl.step = 1'b1;
                cnt_next  = cnt_reg + CNTW'(1);
                if (cnt_reg + CNTW'(1) == CNTW'(s_reg))
                    state_next = ST_RND;
            end
            ST_RND:
            begin
                mode       = CELL_INC;
                ovf_next   = ovf_reg | cout[MAX_DISPLAYS-1];
                state_next = ST_CHK2;
            end
            ST_CHK2:
            begin
                cnt_next = '0;
                idx_next = '0;
                if (hi_err)
                begin
                    err_next   = 1'b1;
                    state_next = ST_OUT;
                end
                else if (low_nz)
                begin
                    dp_next    = 1'b1;
                    used_next  = n_eff;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                mode     = CELL_SHR;
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg + CNTW'(1) == CNTW'(s_reg))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                used_next  = d_cnt;
                idx_next   = '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    mode     = CELL_SHR;
                    idx_next = idx_reg + IDX_W'(1);
                    if (is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dcount_reg <= DCOUNT_RESET;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            err_reg    <= 1'b0;
            dp_reg     <= 1'b0;
            s_reg      <= '0;
            used_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            dcount_reg <= dcount_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            err_reg    <= err_next;
            dp_reg     <= dp_next;
            s_reg      <= s_next;
            used_reg   <= used_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg <= ip_next;
    end

endmodule
